// ===== rtl/ers_pkg.sv =====
// ----------------------------------------------------------------------------
// ers_pkg
// Types and constants shared by the emission rate scheduler files.
// ----------------------------------------------------------------------------
package ers_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int T_BITS = 28;
    localparam int DIV_W = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TELEPORT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIM = 3'd4;

    typedef struct packed {
        logic               kind;
        logic [15:0]        delta_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] spawn_x;
        logic signed [31:0] spawn_y;
        logic signed [31:0] spawn_z;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [DIV_W-1:0] rem0;
        logic [DIV_W-1:0] num;
        logic [32:0]      den;
        logic [5:0]       steps;
    } t_div_req;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ,
        ST_SUM,
        ST_SQRT,
        ST_PLAN,
        ST_DIVC,
        ST_DCQ,
        ST_CNT,
        ST_DIVM,
        ST_REST,
        ST_TGO,
        ST_TDIV,
        ST_TLOAD,
        ST_MUL,
        ST_OUT,
        ST_FLAT,
        ST_FIN
    } t_state;

endpackage

// ===== rtl/ers_div.sv =====
// ----------------------------------------------------------------------------
// ers_div
// Restoring divider, one quotient bit per cycle, remainder preload.
// ----------------------------------------------------------------------------
module ers_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  ers_pkg::t_div_req       i_req,
    output logic                    o_done,
    output logic [ers_pkg::DIV_W-1:0] o_quot,
    output logic [ers_pkg::DIV_W-1:0] o_rem
);

    logic                      r_busy;
    logic [5:0]                r_cnt;
    logic [ers_pkg::DIV_W-1:0] r_rem;
    logic [ers_pkg::DIV_W-1:0] r_num;
    logic [ers_pkg::DIV_W-1:0] r_quot;
    logic [32:0]               r_den;
    logic [ers_pkg::DIV_W:0]   sh;
    logic [ers_pkg::DIV_W:0]   diff;
    logic                      ge;

    assign sh   = {r_rem, r_num[ers_pkg::DIV_W-1]};
    assign ge   = sh >= {2'b00, r_den};
    assign diff = sh - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
            r_rem  <= i_req.rem0;
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[ers_pkg::DIV_W-1:0] : sh[ers_pkg::DIV_W-1:0];
            r_quot <= {r_quot[ers_pkg::DIV_W-2:0], ge};
            r_num  <= {r_num[ers_pkg::DIV_W-2:0], 1'b0};
            r_cnt  <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == 6'd1);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/emission_rate_scheduler.sv =====
// ----------------------------------------------------------------------------
// emission_rate_scheduler
// Turns frame ticks into spawn positions from time credit and path spacing.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready) takes one tick or restart per
// transfer; output channel (o_out_valid/i_out_ready) gives one spawn per
// transfer, last set on the final spawn of a tick. Registers are written
// through i_cfg_we/i_cfg_idx/i_cfg_wdata, by the user only while the block is
// idle; the block itself does not enforce this. A restart is taken in idle; a
// stopped tick goes straight to the finish state. A one-shot burst gives its
// spawns from the flat state, one per cycle while the receiver is ready.
// A loop mode tick runs a bit-serial squaring and a square root first; a still
// or teleport tick then gives its spawns at the current position.
// A moving tick adds two divisions through the shared divider (the first
// skipped when the path is too short for a spawn), then for each spawn a
// fraction division and a shift-add multiply on all three axes.
// o_in_ready is high only between ticks; a spawn sitting in the output
// register does not hold off the next tick, but a stalled receiver holds
// the spawn sequence at the output register.
// Reset returns the registers to their defaults, clears the credit,
// distance rest and stop flag and drops any pending spawn.
// ----------------------------------------------------------------------------
module emission_rate_scheduler #(
    parameter int MAX_EMIT  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  ers_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output ers_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_we,
    input  logic [ers_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ers_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam logic [63:0] ONE_FX      = 64'd1 << FRAC_BITS;
    localparam logic [31:0] MIN_SPACING = 32'((ONE_FX + 64'd999) / 64'd1000);
    localparam logic [31:0] MIN_MOVE    = 32'(ONE_FX / 64'd10000);
    localparam int          CW          = $clog2(MAX_EMIT + 1);
    localparam logic [63:0] T_HALF      = 64'd1 << (ers_pkg::T_BITS - 1);

    ers_pkg::t_state r_state, n_state;

    logic        r_loop_mode;
    logic [15:0] r_rate;
    logic [31:0] r_spacing;
    logic [31:0] r_tele;
    logic [6:0]  r_flim;

    logic [15:0] r_credit;
    logic [31:0] r_rest;
    logic        r_have_prev;
    logic        r_stopped;

    logic [31:0] r_prev [3];
    logic [31:0] r_cur  [3];
    logic [31:0] r_mag  [3];
    logic        r_neg  [3];
    logic [63:0] r_acc  [3];
    logic [31:0] r_mpl  [3];

    logic [5:0]    r_step;
    logic [15:0]   r_tc;
    logic [65:0]   r_sqv;
    logic [34:0]   r_sqrem;
    logic [32:0]   r_root;
    logic [35:0]   r_ed;
    logic [34:0]   r_dc;
    logic [CW-1:0] r_cnt_n;
    logic [CW-1:0] r_idx;
    logic          r_path;

    logic               r_out_valid;
    ers_pkg::t_out_item r_out;

    logic                      in_ready;
    logic                      load_out;
    logic                      div_start;
    ers_pkg::t_div_req         div_req;
    logic                      div_done;
    logic [ers_pkg::DIV_W-1:0] div_quot;
    logic [ers_pkg::DIV_W-1:0] div_rem;

    logic [31:0]   sp;
    logic [CW-1:0] lim;
    logic [CW-1:0] oneshot_n;
    logic [CW-1:0] flat_n;
    logic [31:0]   in_pos [3];
    logic [31:0]   eff_prev [3];
    logic [32:0]   delta [3];
    logic [31:0]   sum;
    logic          tele;
    logic          moving;
    logic [32:0]   first;
    logic          first_le;
    logic [34:0]   dc_max;
    logic [CW-1:0] cnt_sel;
    logic [33:0]   ed_clip;
    logic [33:0]   frac_x;
    logic [36:0]   sq_sh;
    logic [36:0]   sq_trial;
    logic          is_last;
    logic [31:0]   lerp_v [3];
    logic [63:0]   off_w  [3];

    ers_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    assign sp = (r_spacing > MIN_SPACING) ? r_spacing : MIN_SPACING;

    always_comb begin
        if (r_flim == 7'd0) begin
            lim = CW'(1);
        end else if (r_flim > 7'(MAX_EMIT)) begin
            lim = CW'(MAX_EMIT);
        end else begin
            lim = r_flim[CW-1:0];
        end
    end

    assign oneshot_n = (r_rate > 16'(MAX_EMIT)) ? CW'(MAX_EMIT) : r_rate[CW-1:0];
    assign flat_n    = (r_tc > 16'(lim)) ? lim : r_tc[CW-1:0];
    assign sum       = {16'd0, r_credit} + r_rate * i_in_data.delta_time;

    assign in_pos[0] = i_in_data.pos_x;
    assign in_pos[1] = i_in_data.pos_y;
    assign in_pos[2] = i_in_data.pos_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            eff_prev[k] = r_have_prev ? r_prev[k] : in_pos[k];
            delta[k]    = {in_pos[k][31], in_pos[k]} - {eff_prev[k][31], eff_prev[k]};
            off_w[k]    = (r_acc[k] + T_HALF) >> ers_pkg::T_BITS;
            lerp_v[k]   = r_neg[k] ? r_prev[k] - off_w[k][31:0]
                                   : r_prev[k] + off_w[k][31:0];
        end
    end

    assign tele     = (r_tele != 32'd0) && (r_root > {1'b0, r_tele});
    assign moving   = (r_root > {1'b0, MIN_MOVE}) && !tele;
    assign first    = {1'b0, sp} - {1'b0, r_rest};
    assign first_le = $signed({{2{first[32]}}, first}) <= $signed({2'b00, r_root});
    assign dc_max   = (r_dc > {19'd0, r_tc}) ? r_dc : {19'd0, r_tc};
    assign cnt_sel  = (dc_max > 35'(lim)) ? lim : dc_max[CW-1:0];
    assign ed_clip  = r_ed[35] ? 34'd0 : r_ed[33:0];
    assign frac_x   = r_path ? ed_clip : 34'(r_idx) + 34'd1;
    assign sq_sh    = {r_sqrem, r_sqv[65:64]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign is_last  = (r_idx == r_cnt_n - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ers_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        in_ready  = 1'b0;
        load_out  = 1'b0;
        div_start = 1'b0;
        div_req   = '0;
        case (r_state)
            ers_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid && !i_in_data.kind) begin
                    if (r_stopped) begin
                        n_state = ers_pkg::ST_FIN;
                    end else if (!r_loop_mode) begin
                        n_state = (oneshot_n != '0) ? ers_pkg::ST_FLAT : ers_pkg::ST_FIN;
                    end else begin
                        n_state = ers_pkg::ST_SQ;
                    end
                end
            end
            ers_pkg::ST_SQ: begin
                if (r_step == 6'd1) begin
                    n_state = ers_pkg::ST_SUM;
                end
            end
            ers_pkg::ST_SUM: begin
                n_state = ers_pkg::ST_SQRT;
            end
            ers_pkg::ST_SQRT: begin
                if (r_step == 6'd1) begin
                    n_state = ers_pkg::ST_PLAN;
                end
            end
            ers_pkg::ST_PLAN: begin
                if (moving) begin
                    if (first_le) begin
                        div_start     = 1'b1;
                        div_req.num   = {1'b0, r_root} - {first[32], first};
                        div_req.den   = {1'b0, sp};
                        div_req.steps = 6'(ers_pkg::DIV_W);
                        n_state       = ers_pkg::ST_DIVC;
                    end else begin
                        n_state = ers_pkg::ST_CNT;
                    end
                end else begin
                    n_state = (flat_n != '0) ? ers_pkg::ST_FLAT : ers_pkg::ST_FIN;
                end
            end
            ers_pkg::ST_DIVC: begin
                if (div_done) begin
                    n_state = ers_pkg::ST_DCQ;
                end
            end
            ers_pkg::ST_DCQ: begin
                n_state = ers_pkg::ST_CNT;
            end
            ers_pkg::ST_CNT: begin
                div_start     = 1'b1;
                div_req.num   = {2'b00, r_rest} + {1'b0, r_root};
                div_req.den   = {1'b0, sp};
                div_req.steps = 6'(ers_pkg::DIV_W);
                n_state       = ers_pkg::ST_DIVM;
            end
            ers_pkg::ST_DIVM: begin
                if (div_done) begin
                    n_state = ers_pkg::ST_REST;
                end
            end
            ers_pkg::ST_REST: begin
                n_state = (r_cnt_n != '0) ? ers_pkg::ST_TGO : ers_pkg::ST_FIN;
            end
            ers_pkg::ST_TGO: begin
                div_start     = 1'b1;
                div_req.rem0  = {1'b0, frac_x[33:1]};
                div_req.num   = {frac_x[0], 33'd0};
                div_req.den   = r_path ? r_root : 33'(r_cnt_n);
                div_req.steps = 6'(ers_pkg::T_BITS + 1);
                n_state       = ers_pkg::ST_TDIV;
            end
            ers_pkg::ST_TDIV: begin
                if (div_done) begin
                    n_state = ers_pkg::ST_TLOAD;
                end
            end
            ers_pkg::ST_TLOAD: begin
                n_state = ers_pkg::ST_MUL;
            end
            ers_pkg::ST_MUL: begin
                if (r_step == 6'd1) begin
                    n_state = ers_pkg::ST_OUT;
                end
            end
            ers_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = is_last ? ers_pkg::ST_FIN : ers_pkg::ST_TGO;
                end
            end
            ers_pkg::ST_FLAT: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = is_last ? ers_pkg::ST_FIN : ers_pkg::ST_FLAT;
                end
            end
            ers_pkg::ST_FIN: begin
                n_state = ers_pkg::ST_IDLE;
            end
            default: begin
                n_state = ers_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_mode <= 1'b1;
            r_rate      <= 16'd10;
            r_spacing   <= 32'd65536;
            r_tele      <= 32'd0;
            r_flim      <= 7'd64;
            r_credit    <= 16'd0;
            r_rest      <= 32'd0;
            r_have_prev <= 1'b0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_prev[k] <= 32'd0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ers_pkg::CFG_LOOP_MODE: r_loop_mode <= i_cfg_wdata[0];
                    ers_pkg::CFG_RATE:      r_rate      <= i_cfg_wdata[15:0];
                    ers_pkg::CFG_SPACING:   r_spacing   <= i_cfg_wdata;
                    ers_pkg::CFG_TELEPORT:  r_tele      <= i_cfg_wdata;
                    ers_pkg::CFG_FRAME_LIM: r_flim      <= i_cfg_wdata[6:0];
                    default: ;
                endcase
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ers_pkg::ST_IDLE: begin
                    if (i_in_valid && i_in_data.kind) begin
                        r_credit    <= 16'd0;
                        r_rest      <= 32'd0;
                        r_have_prev <= 1'b0;
                        r_stopped   <= 1'b0;
                    end else if (i_in_valid) begin
                        r_have_prev <= 1'b1;
                        r_idx       <= '0;
                        r_step      <= 6'd32;
                        for (int k = 0; k < 3; k++) begin
                            r_cur[k]  <= in_pos[k];
                            r_prev[k] <= eff_prev[k];
                            r_neg[k]  <= delta[k][32];
                            r_mag[k]  <= delta[k][32] ? 32'(-delta[k]) : delta[k][31:0];
                            r_mpl[k]  <= delta[k][32] ? 32'(-delta[k]) : delta[k][31:0];
                            r_acc[k]  <= 64'd0;
                        end
                        if (!r_stopped && !r_loop_mode) begin
                            r_stopped <= 1'b1;
                            r_cnt_n   <= oneshot_n;
                        end else if (!r_stopped) begin
                            r_credit <= sum[15:0];
                            r_tc     <= sum[31:16];
                        end
                    end
                end
                ers_pkg::ST_SQ, ers_pkg::ST_MUL: begin
                    r_step <= r_step - 6'd1;
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k] <= {r_acc[k][62:0], 1'b0}
                                  + (r_mpl[k][31] ? {32'd0, r_mag[k]} : 64'd0);
                        r_mpl[k] <= {r_mpl[k][30:0], 1'b0};
                    end
                end
                ers_pkg::ST_SUM: begin
                    r_sqv   <= {2'b00, r_acc[0]} + {2'b00, r_acc[1]} + {2'b00, r_acc[2]};
                    r_sqrem <= '0;
                    r_root  <= '0;
                    r_step  <= 6'd33;
                end
                ers_pkg::ST_SQRT: begin
                    r_step <= r_step - 6'd1;
                    r_sqv  <= {r_sqv[63:0], 2'b00};
                    if (sq_sh >= sq_trial) begin
                        r_sqrem <= 35'(sq_sh - sq_trial);
                        r_root  <= {r_root[31:0], 1'b1};
                    end else begin
                        r_sqrem <= sq_sh[34:0];
                        r_root  <= {r_root[31:0], 1'b0};
                    end
                end
                ers_pkg::ST_PLAN: begin
                    r_ed <= {{3{first[32]}}, first};
                    r_dc <= '0;
                    if (!moving) begin
                        r_cnt_n <= flat_n;
                        if (tele) begin
                            r_rest <= 32'd0;
                        end
                    end
                end
                ers_pkg::ST_DCQ: begin
                    r_dc <= {1'b0, div_quot} + 35'd1;
                end
                ers_pkg::ST_CNT: begin
                    r_cnt_n <= cnt_sel;
                    r_path  <= r_dc >= {19'd0, r_tc};
                end
                ers_pkg::ST_REST: begin
                    r_rest <= div_rem[31:0];
                end
                ers_pkg::ST_TLOAD: begin
                    r_step <= 6'(ers_pkg::T_BITS + 1);
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k] <= 64'd0;
                        r_mpl[k] <= {div_quot[ers_pkg::T_BITS:0], 3'b000};
                    end
                end
                ers_pkg::ST_OUT: begin
                    if (load_out) begin
                        r_out.spawn_x <= lerp_v[0];
                        r_out.spawn_y <= lerp_v[1];
                        r_out.spawn_z <= lerp_v[2];
                        r_out.last    <= is_last;
                        r_idx         <= r_idx + CW'(1);
                        r_ed          <= r_ed + {4'd0, sp};
                    end
                end
                ers_pkg::ST_FLAT: begin
                    if (load_out) begin
                        r_out.spawn_x <= r_cur[0];
                        r_out.spawn_y <= r_cur[1];
                        r_out.spawn_z <= r_cur[2];
                        r_out.last    <= is_last;
                        r_idx         <= r_idx + CW'(1);
                    end
                end
                ers_pkg::ST_FIN: begin
                    for (int k = 0; k < 3; k++) begin
                        r_prev[k] <= r_cur[k];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/ers_chk.sv =====
// ----------------------------------------------------------------------------
// ers_chk
// Port-level checks for the emission rate scheduler.
// ----------------------------------------------------------------------------
module ers_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input ers_pkg::t_in_item              i_in_data,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input ers_pkg::t_out_item             o_out_data,
    input logic                           i_cfg_we,
    input logic [ers_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [ers_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("spawn dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("spawn pending after reset");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_data.kind |=> !o_in_ready)
        else $error("tick transfer did not occupy the scheduler");

    a_restart_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.kind && !o_out_valid |=> !o_out_valid)
        else $error("restart produced a spawn");

endmodule

bind emission_rate_scheduler ers_chk u_ers_chk (.*);

// ===== tb/emission_rate_scheduler_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// emission_rate_scheduler_checker
// Watches the tick, spawn and register ports, predicts every spawn of every
// accepted tick and compares each spawn transfer field by field in order.
// ----------------------------------------------------------------------------
module emission_rate_scheduler_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  ers_pkg::t_in_item                  i_in_data,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  ers_pkg::t_out_item                 i_out_data,
    input  logic                               i_cfg_we,
    input  logic [ers_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ers_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output int                                 o_errors,
    output int                                 o_pending
);

    localparam int EMIT_MAX = 64;
    localparam longint SPACING_FLOOR = 66;
    localparam longint MOVE_FLOOR = 6;

    bit          loop_on;
    bit [15:0]   rate;
    bit [31:0]   spacing;
    bit [31:0]   jump_limit;
    bit [6:0]    tick_limit;
    bit [15:0]   credit;
    bit [31:0]   path_rest;
    longint      last_x, last_y, last_z;
    bit          have_last, halted;

    ers_pkg::t_out_item spawn_q[$];
    int                 errors;

    assign o_errors  = errors;
    assign o_pending = spawn_q.size();

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic bit [63:0] magnitude(input longint d);
        return d < 0 ? -d : d;
    endfunction

    function automatic bit [63:0] root_floor(input bit [67:0] v);
        bit [63:0] r, rem, trial;
        r = 0;
        rem = 0;
        for (int p = 33; p >= 0; p--) begin
            rem = (rem << 2) | 64'((v >> (2 * p)) & 68'd3);
            trial = (r << 2) | 64'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                r = (r << 1) | 64'd1;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    function automatic bit [31:0] blend(input longint a, input longint b, input bit [63:0] t);
        longint d;
        bit [63:0] off;
        longint r;
        d = b - a;
        off = (magnitude(d) * t + (64'd1 << (ers_pkg::T_BITS - 1))) >> ers_pkg::T_BITS;
        r = d < 0 ? a - longint'(off) : a + longint'(off);
        return r[31:0];
    endfunction

    function automatic void add_spawn(input bit [31:0] x, input bit [31:0] y,
                                      input bit [31:0] z, input bit fin);
        ers_pkg::t_out_item s;
        s.spawn_x = x;
        s.spawn_y = y;
        s.spawn_z = z;
        s.last = fin;
        spawn_q.push_back(s);
    endfunction

    function automatic void predict_spawns(input ers_pkg::t_in_item it);
        longint cx, cy, cz, first, ed;
        bit [63:0] sp, lim, sum, tc, dc, cnt, t, path_len, mx, my, mz;
        bit [67:0] sq;
        bit tele;
        int n;
        if (it.kind) begin
            credit = 0;
            path_rest = 0;
            halted = 0;
            have_last = 0;
            return;
        end
        cx = longint'(it.pos_x);
        cy = longint'(it.pos_y);
        cz = longint'(it.pos_z);
        if (!have_last) begin
            last_x = cx;
            last_y = cy;
            last_z = cz;
            have_last = 1;
        end
        if (!halted) begin
            if (!loop_on) begin
                n = rate > EMIT_MAX ? EMIT_MAX : int'(rate);
                for (int i = 0; i < n; i++)
                    add_spawn(cx[31:0], cy[31:0], cz[31:0], i == n - 1);
                halted = 1;
            end else begin
                sp = spacing > SPACING_FLOOR ? 64'(spacing) : 64'(SPACING_FLOOR);
                lim = tick_limit < 1 ? 64'd1 : 64'(tick_limit);
                if (lim > EMIT_MAX)
                    lim = EMIT_MAX;
                sum = 64'(credit) + 64'(rate) * 64'(it.delta_time);
                tc = sum >> 16;
                credit = sum[15:0];
                mx = magnitude(cx - last_x);
                my = magnitude(cy - last_y);
                mz = magnitude(cz - last_z);
                sq = 68'(mx) * 68'(mx) + 68'(my) * 68'(my) + 68'(mz) * 68'(mz);
                path_len = root_floor(sq);
                tele = jump_limit != 0 && path_len > 64'(jump_limit);
                if (path_len > MOVE_FLOOR && !tele) begin
                    first = longint'(sp) - longint'(path_rest);
                    dc = 0;
                    if (first <= longint'(path_len))
                        dc = 64'(longint'(path_len) - first) / sp + 64'd1;
                    cnt = tc > dc ? tc : dc;
                    if (cnt > lim)
                        cnt = lim;
                    n = int'(cnt);
                    for (int i = 0; i < n; i++) begin
                        if (dc >= tc) begin
                            ed = first + longint'(sp) * i;
                            if (ed < 0)
                                ed = 0;
                            t = (64'(ed) << ers_pkg::T_BITS) / path_len;
                        end else begin
                            t = (64'(i + 1) << ers_pkg::T_BITS) / cnt;
                        end
                        add_spawn(blend(last_x, cx, t), blend(last_y, cy, t),
                                  blend(last_z, cz, t), i == n - 1);
                    end
                    path_rest = 32'((64'(path_rest) + path_len) % sp);
                end else begin
                    n = int'(tc > lim ? lim : tc);
                    for (int i = 0; i < n; i++)
                        add_spawn(cx[31:0], cy[31:0], cz[31:0], i == n - 1);
                    if (tele)
                        path_rest = 0;
                end
            end
        end
        last_x = cx;
        last_y = cy;
        last_z = cz;
    endfunction

    always @(posedge i_clk) begin
        ers_pkg::t_out_item want;
        if (!i_rst_n) begin
            loop_on = 1;
            rate = 10;
            spacing = 32'd65536;
            jump_limit = 0;
            tick_limit = 7'd64;
            credit = 0;
            path_rest = 0;
            last_x = 0;
            last_y = 0;
            last_z = 0;
            have_last = 0;
            halted = 0;
            spawn_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (spawn_q.size() == 0) begin
                    report($sformatf("unexpected spawn %h", i_out_data));
                end else begin
                    want = spawn_q[0];
                    spawn_q.delete(0);
                    if (i_out_data.spawn_x !== want.spawn_x)
                        report($sformatf("spawn_x %h, want %h", i_out_data.spawn_x,
                                         want.spawn_x));
                    if (i_out_data.spawn_y !== want.spawn_y)
                        report($sformatf("spawn_y %h, want %h", i_out_data.spawn_y,
                                         want.spawn_y));
                    if (i_out_data.spawn_z !== want.spawn_z)
                        report($sformatf("spawn_z %h, want %h", i_out_data.spawn_z,
                                         want.spawn_z));
                    if (i_out_data.last !== want.last)
                        report($sformatf("last %b, want %b", i_out_data.last, want.last));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ers_pkg::CFG_LOOP_MODE: loop_on = i_cfg_wdata[0];
                    ers_pkg::CFG_RATE:      rate = i_cfg_wdata[15:0];
                    ers_pkg::CFG_SPACING:   spacing = i_cfg_wdata;
                    ers_pkg::CFG_TELEPORT:  jump_limit = i_cfg_wdata;
                    ers_pkg::CFG_FRAME_LIM: tick_limit = i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_spawns(i_in_data);
        end
    end

endmodule

// ===== tb/emission_rate_scheduler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// emission_rate_scheduler_test
// Drives ticks and restarts under several register settings with random
// gaps and receiver stalls; the checker predicts and compares every spawn.
// ----------------------------------------------------------------------------
module emission_rate_scheduler_test;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_ready;
    ers_pkg::t_in_item                  i_in_data;
    logic                               o_out_valid;
    logic                               i_out_ready;
    ers_pkg::t_out_item                 o_out_data;
    logic                               i_cfg_we;
    logic [ers_pkg::CFG_IDX_W-1:0]      i_cfg_idx;
    logic [ers_pkg::CFG_DATA_W-1:0]     i_cfg_wdata;
    int                                 errors;
    int                                 pending;
    bit                                 busy_stretch;
    logic signed [31:0]                 at_x, at_y, at_z;

    emission_rate_scheduler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    emission_rate_scheduler_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("[emission_rate_scheduler] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (busy_stretch)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, one long hold-off early in the run
    initial begin
        int cyc;
        int hold;
        i_out_ready = 0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == 3000) begin
                i_out_ready <= 0;
                for (hold = 0; hold < 5000; hold++)
                    @(posedge i_clk);
            end
            if (busy_stretch)
                i_out_ready <= 1;
            else if ($urandom_range(0, 29) == 0)
                i_out_ready <= 0;
            else if ($urandom_range(0, 2) != 0)
                i_out_ready <= 1;
            else if ($urandom_range(0, 3) == 0)
                i_out_ready <= 0;
        end
    end

    task automatic send(input ers_pkg::t_in_item it);
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic tick(input logic [15:0] dt, input logic signed [31:0] x,
                        input logic signed [31:0] y, input logic signed [31:0] z);
        ers_pkg::t_in_item it;
        it.kind = 0;
        it.delta_time = dt;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        send(it);
    endtask

    task automatic restart();
        ers_pkg::t_in_item it;
        it.kind = 1;
        it.delta_time = 16'($urandom);
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.pos_z = $urandom;
        send(it);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic configure(input logic lm, input logic [15:0] r, input logic [31:0] sp,
                             input logic [31:0] tl, input logic [6:0] fl);
        drain();
        i_cfg_we <= 1;
        i_cfg_idx <= ers_pkg::CFG_LOOP_MODE;
        i_cfg_wdata <= 32'(lm);
        @(posedge i_clk);
        i_cfg_idx <= ers_pkg::CFG_RATE;
        i_cfg_wdata <= 32'(r);
        @(posedge i_clk);
        i_cfg_idx <= ers_pkg::CFG_SPACING;
        i_cfg_wdata <= sp;
        @(posedge i_clk);
        i_cfg_idx <= ers_pkg::CFG_TELEPORT;
        i_cfg_wdata <= tl;
        @(posedge i_clk);
        i_cfg_idx <= ers_pkg::CFG_FRAME_LIM;
        i_cfg_wdata <= 32'(fl);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic wander(input int items, input int jump_scale);
        int r;
        for (int k = 0; k < items; k++) begin
            busy_stretch = (k % 40) < 8;
            r = $urandom_range(0, 99);
            if (r < 5) begin
                restart();
            end else begin
                if (r < 15) begin
                    at_x = $urandom;
                    at_y = $urandom;
                    at_z = $urandom;
                end else if (r < 70) begin
                    at_x = at_x + $signed($urandom_range(0, 2 << jump_scale)) - (1 << jump_scale);
                    at_y = at_y + $signed($urandom_range(0, 2 << jump_scale)) - (1 << jump_scale);
                    at_z = at_z + $signed($urandom_range(0, 2 << jump_scale)) - (1 << jump_scale);
                end else if (r < 80) begin
                    at_x = at_x + $signed($urandom_range(0, 6)) - 3;
                end
                if ($urandom_range(0, 9) == 0)
                    tick(16'($urandom), at_x, at_y, at_z);
                else
                    tick(16'($urandom_range(0, 4000)), at_x, at_y, at_z);
            end
        end
        busy_stretch = 0;
    endtask

    initial begin
        logic [31:0] sp;
        logic [31:0] tl;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_data = '0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        busy_stretch = 0;
        at_x = 0;
        at_y = 0;
        at_z = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // defaults: first tick, still, moving, extremes of time and position
        tick(16'hFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0);
        tick(16'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0);
        tick(16'd6554, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0);
        tick(16'd1000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        tick(16'd1000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFF000);
        tick(16'd1000, 32'sh80000003, 32'sh7FFFFFFF, 32'sh7FFFF000);
        restart();
        tick(16'd3000, 32'sd0, 32'sd0, 32'sd0);
        tick(16'd3000, 32'sh00050000, 32'sd0, 32'sd0);

        // zero spacing (clamped to the floor), teleport threshold, one-spawn frame limit
        configure(1, 16'hFFFF, 32'd0, 32'h00080000, 7'd1);
        tick(16'hFFFF, 32'sh00010000, 32'sd0, 32'sd0);
        tick(16'd100, 32'sh00030000, 32'sh00010000, 32'sd0);
        tick(16'd100, 32'sh00400000, 32'sd0, 32'sd0);
        tick(16'd100, 32'sh00400004, 32'sd0, 32'sd0);

        // frame limit zero clamps to one; lowered spacing after a large one
        configure(1, 16'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 7'd0);
        tick(16'd500, 32'sh00100000, 32'sd0, 32'sd0);
        tick(16'd500, 32'sh00200000, 32'sh00100000, 32'sd0);
        configure(1, 16'd2000, 32'd66, 32'd0, 7'd64);
        tick(16'd500, 32'sh00200100, 32'sh00100000, 32'sd0);
        tick(16'd20, 32'sh00200000, 32'sh00100000, 32'sh00000001);

        // one-shot: saturated burst, then silent until restart
        configure(0, 16'hFFFF, 32'd65536, 32'd0, 7'd127);
        tick(16'd1, 32'sh12345678, 32'sh9ABCDEF0, 32'sh0F0F0F0F);
        tick(16'd1, 32'sd0, 32'sd0, 32'sd0);
        restart();
        configure(0, 16'd0, 32'd65536, 32'd0, 7'd64);
        tick(16'd100, 32'sh00000010, 32'sd0, 32'sd0);
        configure(0, 16'd3, 32'd65536, 32'd0, 7'd64);
        restart();
        tick(16'd100, 32'sh00000020, 32'sd0, 32'sd0);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: sp = 32'($urandom_range(66, 1 << 20));
                1: sp = 32'd0;
                2: sp = $urandom;
                default: sp = 32'hFFFFFFFF;
            endcase
            case ($urandom_range(0, 3))
                0: tl = 0;
                1: tl = 32'($urandom_range(1, 1 << 22));
                2: tl = 32'hFFFFFFFF;
                default: tl = $urandom;
            endcase
            configure(ph != 5, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200)),
                      sp, tl,
                      7'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 8)));
            restart();
            wander(40, 10 + 2 * ph);
        end

        drain();
        if (errors == 0)
            $display("[emission_rate_scheduler] OK");
        else
            $display("[emission_rate_scheduler] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ers_pkg.sv
rtl/ers_div.sv
rtl/emission_rate_scheduler.sv
rtl/ers_chk.sv
tb/emission_rate_scheduler_checker.sv
tb/emission_rate_scheduler_test.sv
